@@ rtl/core/shrb_pkg.sv @@
// ----------------------------------------------------------------------------
// shrb_pkg
// Shared types and constants of the sample history ring buffer: channel
// payloads, store entry layout, command codes and controller/datapath links.
// ----------------------------------------------------------------------------
package shrb_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned WIN_W    = 16;
	localparam int unsigned WIN_MS_W = 26;
	localparam int unsigned MS_W     = 10;

	// milliseconds per second for the range read window
	localparam logic [MS_W-1:0] MS_PER_SECOND = 10'd1000;

	// capacity after reset, before clamping to the store depth
	localparam int unsigned CAP_RESET = 64;

	typedef enum logic [1:0] {
		CMD_ADD         = 2'd0,
		CMD_READ_OFFSET = 2'd1,
		CMD_READ_RANGE  = 2'd2,
		CMD_CLEAR       = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CUTOFF,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		cmd_t                command;
		logic                sample_valid;
		logic [WORD_W-1:0]   sample_time;
		logic [WORD_W-1:0]   value_a;
		logic [WORD_W-1:0]   value_b;
		logic [WORD_W-1:0]   value_c;
		logic [WORD_W-1:0]   value_d;
		logic [COUNT_W-1:0]  max_count;
		logic [COUNT_W-1:0]  start_offset;
		logic [WIN_W-1:0]    window_seconds;
		logic [COUNT_W-1:0]  keep_every;
	} req_t;

	typedef struct packed {
		logic                has_entry;
		logic [WORD_W-1:0]   entry_time;
		logic [WORD_W-1:0]   entry_a;
		logic [WORD_W-1:0]   entry_b;
		logic [WORD_W-1:0]   entry_c;
		logic [WORD_W-1:0]   entry_d;
		logic [COUNT_W-1:0]  stored_count;
		logic                last;
	} rsp_t;

	typedef struct packed {
		logic [WORD_W-1:0] stamp;
		logic [WORD_W-1:0] val_a;
		logic [WORD_W-1:0] val_b;
		logic [WORD_W-1:0] val_c;
		logic [WORD_W-1:0] val_d;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load_cutoff;
		logic scan;
		logic finish;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

@@ rtl/core/shrb_if.sv @@
// ----------------------------------------------------------------------------
// shrb_if
// Valid/ready channels of the sample history ring buffer: request, response
// and capacity register write.
// ----------------------------------------------------------------------------
interface shrb_req_if;
	logic          valid;
	logic          ready;
	shrb_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface shrb_rsp_if;
	logic          valid;
	logic          ready;
	shrb_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface shrb_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [shrb_pkg::COUNT_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/shrb_ctrl.sv @@
// ----------------------------------------------------------------------------
// shrb_ctrl
// Command sequencer: takes one request beat, steers the datapath through
// cutoff lookup (range reads), store scan (reads) and the closing result.
// ----------------------------------------------------------------------------
module shrb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  shrb_pkg::cmd_t      in_command,
	output logic                in_ready,
	input  shrb_pkg::ctrl_sts_t sts,
	output shrb_pkg::ctrl_cmd_t cmd
);

	shrb_pkg::state_t state_q;
	shrb_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shrb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			shrb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (in_command)
						shrb_pkg::CMD_READ_OFFSET: state_d = shrb_pkg::ST_SCAN;
						shrb_pkg::CMD_READ_RANGE:  state_d = shrb_pkg::ST_CUTOFF;
						default:                   state_d = shrb_pkg::ST_FINISH;
					endcase
				end
			end
			shrb_pkg::ST_CUTOFF: begin
				cmd.load_cutoff = 1'b1;
				state_d         = shrb_pkg::ST_SCAN;
			end
			shrb_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = shrb_pkg::ST_FINISH;
				end
			end
			shrb_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				if (sts.out_free) begin
					state_d = shrb_pkg::ST_IDLE;
				end
			end
			default: state_d = shrb_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ rtl/core/shrb_dp.sv @@
// ----------------------------------------------------------------------------
// shrb_dp
// Datapath: sample store, write pointer and fill level, scan counters,
// window filter, one-entry lookahead and the response register.
// ----------------------------------------------------------------------------
module shrb_dp #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  shrb_pkg::ctrl_cmd_t           cmd,
	output shrb_pkg::ctrl_sts_t           sts,
	input  shrb_pkg::req_t                req,
	input  logic                          cfg_valid,
	input  logic [shrb_pkg::COUNT_W-1:0]  cfg_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output shrb_pkg::rsp_t                out_data
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = ((CW > shrb_pkg::COUNT_W) ? CW : shrb_pkg::COUNT_W) + 1;
	localparam int unsigned RESET_CAP_I =
		(DEPTH < shrb_pkg::CAP_RESET) ? DEPTH : shrb_pkg::CAP_RESET;
	localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
	localparam logic [CW-1:0] RESET_CAP = CW'(RESET_CAP_I);

	// store
	shrb_pkg::entry_t mem [DEPTH];
	shrb_pkg::entry_t rd_q;
	shrb_pkg::entry_t wr_entry;
	logic             mem_we;
	logic             mem_re;
	logic [AW-1:0]    rd_addr;

	// ring state
	logic [CW-1:0] cap_q;
	logic [AW-1:0] wp_q;
	logic [CW-1:0] fill_q;

	// per command settings
	logic [shrb_pkg::COUNT_W-1:0]  max_q;
	logic [shrb_pkg::COUNT_W-1:0]  every_q;
	logic                          win_zero_q;
	logic [shrb_pkg::WIN_MS_W-1:0] win_ms_q;
	logic [shrb_pkg::WORD_W-1:0]   cutoff_q;

	// scan state
	logic [AW-1:0]                idx_q;
	logic [CW-1:0]                remain_q;
	logic [shrb_pkg::COUNT_W-1:0] n_q;
	logic [shrb_pkg::COUNT_W-1:0] skip_q;
	logic                         rv_q;
	shrb_pkg::entry_t             pend_q;
	logic                         pend_v_q;

	// response register
	logic           out_v_q;
	shrb_pkg::rsp_t out_q;

	logic                         full;
	logic [CW-1:0]                cap_eff;
	logic [AW-1:0]                wp_inc;
	logic [AW-1:0]                idx_inc;
	logic [AW-1:0]                latest_slot;
	logic [AW-1:0]                first_slot;
	logic [SW-1:0]                start_sum;
	logic [shrb_pkg::COUNT_W-1:0] start_off;
	logic [CW-1:0]                remain_d;
	logic                         adv;
	logic                         more;
	logic                         issue;
	logic                         inwin;
	logic                         keep;
	logic                         step;
	logic                         load_out;
	logic [shrb_pkg::COUNT_W-1:0] skip_inc;

	// clamp the written capacity to 1..DEPTH
	always_comb begin
		if (cfg_data == '0) begin
			cap_eff = CW'(1);
		end else if (SW'(cfg_data) > SW'(DEPTH)) begin
			cap_eff = DEPTH_C;
		end else begin
			cap_eff = CW'(cfg_data);
		end
	end

	// pointer arithmetic, all wrapping at the capacity
	assign full        = (fill_q == cap_q);
	assign wp_inc      = ((CW'(wp_q) + CW'(1)) == cap_q) ? '0 : AW'(wp_q + AW'(1));
	assign idx_inc     = ((CW'(idx_q) + CW'(1)) == cap_q) ? '0 : AW'(idx_q + AW'(1));
	assign latest_slot = (wp_q == '0) ? AW'(cap_q - CW'(1)) : AW'(wp_q - AW'(1));

	// first slot of a read: oldest entry plus the offset
	always_comb begin
		start_off = (req.command == shrb_pkg::CMD_READ_OFFSET) ? req.start_offset : '0;
		start_sum = SW'(full ? wp_q : '0) + SW'(start_off);
		if (start_sum >= SW'(cap_q)) begin
			first_slot = AW'(start_sum - SW'(cap_q));
		end else begin
			first_slot = AW'(start_sum);
		end
	end

	// entries a read has to walk
	always_comb begin
		remain_d = '0;
		unique case (req.command)
			shrb_pkg::CMD_READ_OFFSET: begin
				if (req.max_count != '0 && SW'(req.start_offset) < SW'(fill_q)) begin
					remain_d = CW'(SW'(fill_q) - SW'(req.start_offset));
				end
			end
			shrb_pkg::CMD_READ_RANGE: begin
				if (req.max_count != '0 && req.keep_every != '0) begin
					remain_d = fill_q;
				end
			end
			default: remain_d = '0;
		endcase
	end

	// scan step control
	assign adv      = !out_v_q || out_ready;
	assign more     = (remain_q != '0) && (n_q < max_q);
	assign issue    = cmd.scan && adv && more;
	assign step     = cmd.scan && adv && rv_q;
	assign inwin    = win_zero_q || (rd_q.stamp >= cutoff_q);
	assign keep     = rv_q && inwin && (skip_q == '0) && (n_q < max_q);
	assign skip_inc = ((skip_q + 7'd1) == every_q) ? '0 : skip_q + 7'd1;
	assign load_out = (step && keep && pend_v_q) || (cmd.finish && adv);

	assign sts.scan_done = !rv_q && !more;
	assign sts.out_free  = adv;

	// store ports
	assign mem_we  = cmd.accept && (req.command == shrb_pkg::CMD_ADD) && req.sample_valid;
	assign mem_re  = (cmd.accept && (req.command == shrb_pkg::CMD_READ_RANGE)) || issue;
	assign rd_addr = cmd.accept ? latest_slot : idx_q;

	always_comb begin
		wr_entry.stamp = req.sample_time;
		wr_entry.val_a = req.value_a;
		wr_entry.val_b = req.value_b;
		wr_entry.val_c = req.value_c;
		wr_entry.val_d = req.value_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= wr_entry;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= RESET_CAP;
			wp_q     <= '0;
			fill_q   <= '0;
			remain_q <= '0;
			n_q      <= '0;
			skip_q   <= '0;
			rv_q     <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				unique case (req.command)
					shrb_pkg::CMD_ADD: begin
						if (req.sample_valid) begin
							wp_q <= wp_inc;
							if (!full) begin
								fill_q <= fill_q + CW'(1);
							end
						end
					end
					shrb_pkg::CMD_CLEAR: begin
						wp_q   <= '0;
						fill_q <= '0;
					end
					default: begin
					end
				endcase
				remain_q <= remain_d;
				n_q      <= '0;
				skip_q   <= '0;
				rv_q     <= 1'b0;
				pend_v_q <= 1'b0;
			end
			if (cmd.scan && adv) begin
				rv_q <= issue;
				if (issue) begin
					remain_q <= remain_q - CW'(1);
				end
				if (rv_q && inwin) begin
					skip_q <= skip_inc;
				end
				if (keep) begin
					n_q      <= n_q + 7'd1;
					pend_v_q <= 1'b1;
				end
			end
			// capacity write empties the ring
			if (cfg_valid) begin
				cap_q  <= cap_eff;
				wp_q   <= '0;
				fill_q <= '0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// command settings, scan address and lookahead entry
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q      <= first_slot;
			max_q      <= req.max_count;
			every_q    <= (req.command == shrb_pkg::CMD_READ_RANGE) ? req.keep_every : 7'd1;
			win_zero_q <= (req.command != shrb_pkg::CMD_READ_RANGE) || (req.window_seconds == '0);
			win_ms_q   <= shrb_pkg::WIN_MS_W'(shrb_pkg::WIN_MS_W'(req.window_seconds)
				* shrb_pkg::WIN_MS_W'(shrb_pkg::MS_PER_SECOND));
		end
		if (cmd.load_cutoff) begin
			if (rd_q.stamp > shrb_pkg::WORD_W'(win_ms_q)) begin
				cutoff_q <= rd_q.stamp - shrb_pkg::WORD_W'(win_ms_q);
			end else begin
				cutoff_q <= '0;
			end
		end
		if (issue) begin
			idx_q <= idx_inc;
		end
		if (step && keep) begin
			pend_q <= rd_q;
		end
	end

	// response register: earlier entry on a new keep, closing beat at finish
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.has_entry    <= pend_v_q;
			out_q.entry_time   <= pend_v_q ? pend_q.stamp : '0;
			out_q.entry_a      <= pend_v_q ? pend_q.val_a : '0;
			out_q.entry_b      <= pend_v_q ? pend_q.val_b : '0;
			out_q.entry_c      <= pend_v_q ? pend_q.val_c : '0;
			out_q.entry_d      <= pend_v_q ? pend_q.val_d : '0;
			out_q.stored_count <= shrb_pkg::COUNT_W'(fill_q);
			out_q.last         <= cmd.finish;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

@@ rtl/core/sample_history_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// sample_history_ring_buffer
// Circular store of timestamped four-word samples with add, offset read,
// time-window read and clear commands.
// ----------------------------------------------------------------------------
// One request beat is taken at a time; the next is taken once the current
// command has handed its closing beat to the response register. Add and clear
// go straight to the finish state, which loads the closing beat. A read walks
// its entries through the store's single read port, one entry per cycle while
// the response side keeps up. An offset read walks the entries from its offset
// until max_count are kept; a range read first looks up the newest timestamp
// in its cutoff state, then walks the stored entries until max_count are kept.
// Every result beat but the closing one leaves one entry behind the scan, so
// the last flag is exact. The capacity register may be written only between
// commands; it empties the store. There is no clearing pass after reset.
module sample_history_ring_buffer #(
	parameter int unsigned DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	shrb_req_if.sink   req,
	shrb_rsp_if.source rsp,
	shrb_cfg_if.sink   cfg
);

	shrb_pkg::ctrl_cmd_t ctrl_cmd;
	shrb_pkg::ctrl_sts_t ctrl_sts;

	// capacity writes are always taken
	assign cfg.ready = 1'b1;

	// command sequencer
	shrb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_command (req.data.command),
		.in_ready   (req.ready),
		.sts        (ctrl_sts),
		.cmd        (ctrl_cmd)
	);

	// store and scan datapath
	shrb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (ctrl_cmd),
		.sts       (ctrl_sts),
		.req       (req.data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_data  (rsp.data)
	);

endmodule
